FILE: hdl/dodc_pkg.sv
// Package for the decimal digit occurrence counter.
// Holds shared widths, the power-of-ten table and the controller/datapath command type.
// No dependencies.
`default_nettype none
package dodc_pkg;
    localparam int LIMIT_W = 34;
    localparam int CNT_W   = 37;
    localparam int DIG_W   = 4;
    localparam int NUM_DIG = 10;
    localparam int IDX_W   = 4;
    localparam int POW_N   = 20;
    localparam int POW_IW  = 5;

    localparam logic [63:0] POW10 [0:POW_N-1] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
        64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
        64'd100000000000, 64'd1000000000000, 64'd10000000000000,
        64'd100000000000000, 64'd1000000000000000, 64'd10000000000000000,
        64'd100000000000000000, 64'd1000000000000000000,
        64'd10000000000000000000
    };

    typedef struct packed {
        logic             load;
        logic             step;
        logic [POW_IW-1:0] pos;
        logic [IDX_W-1:0]  idx;
    } t_cmd;
endpackage
`default_nettype wire

FILE: hdl/dodc_ctrl.sv
// Controller for the decimal digit occurrence counter.
// Sequences load, one step per decimal position, then ten output transactions.
// Depends on dodc_pkg.
`default_nettype none
module dodc_ctrl
    import dodc_pkg::*;
#(
    parameter int DIGITS = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output logic      o_last,
    output t_cmd      o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [POW_IW-1:0] POS_TOP = POW_IW'(DIGITS - 1);
    localparam logic [IDX_W-1:0]  IDX_TOP = IDX_W'(NUM_DIG - 1);

    logic [1:0]        r_state, n_state;
    logic [POW_IW-1:0] r_pos, n_pos;
    logic [IDX_W-1:0]  r_idx, n_idx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_last      = (r_idx == IDX_TOP);
    assign o_cmd.load  = o_in_ready && i_in_valid;
    assign o_cmd.step  = (r_state == S_CALC);
    assign o_cmd.pos   = r_pos;
    assign o_cmd.idx   = r_idx;

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CALC;
                    n_pos   = POS_TOP;
                end
            end
            S_CALC: begin
                if (r_pos == '0) begin
                    n_state = S_EMIT;
                    n_idx   = '0;
                end else begin
                    n_pos = r_pos - 1'b1;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_idx   <= n_idx;
        end
    end

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid both high");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && r_pos == '0) |=> (o_out_valid && r_idx == '0))
        else $error("emit did not start at digit zero");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("not idle after last result");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (o_cmd.step && r_pos == POS_TOP))
        else $error("calc did not start at top position");
endmodule
`default_nettype wire

FILE: hdl/dodc_dpath.sv
// Datapath for the decimal digit occurrence counter.
// Walks positions from the top down, keeping remainder, prefix term and ten counts.
// Depends on dodc_pkg.
`default_nettype none
module dodc_dpath
    import dodc_pkg::*;
#(
    parameter int DIGITS = 10
) (
    input  wire logic               i_clk,
    input  wire t_cmd               i_cmd,
    input  wire logic [LIMIT_W-1:0] i_upper_limit,
    output logic      [CNT_W-1:0]   o_count
);
    localparam logic [63:0] LIMIT = POW10[DIGITS] - 64'd1;

    logic [LIMIT_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_term;
    logic               r_hnz;
    logic [CNT_W-1:0]   r_cnt [0:NUM_DIG-1];

    logic [63:0]        mult [1:NUM_DIG-1];
    logic [NUM_DIG-2:0] ge;
    logic [DIG_W-1:0]   cur;
    logic [63:0]        sub;
    logic [LIMIT_W-1:0] low;
    logic [CNT_W-1:0]   place, low1, nterm;
    logic [63:0]        pnext;

    always_comb begin
        for (int d = 1; d < NUM_DIG; d++) begin
            mult[d]  = 64'(d) * POW10[i_cmd.pos];
            ge[d-1]  = {{(64-LIMIT_W){1'b0}}, r_rem} >= mult[d];
        end
        cur = DIG_W'($countones(ge));
        sub = (cur == '0) ? 64'd0 : mult[cur];
        low   = r_rem - sub[LIMIT_W-1:0];
        place = POW10[i_cmd.pos][CNT_W-1:0];
        low1  = CNT_W'(low) + 1'b1;
        pnext = (i_cmd.pos == '0) ? 64'd0 : POW10[i_cmd.pos - 1'b1];
        nterm = r_term + CNT_W'(cur) * pnext[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= ({{(64-LIMIT_W){1'b0}}, i_upper_limit} > LIMIT) ?
                      LIMIT[LIMIT_W-1:0] : i_upper_limit;
            r_term <= '0;
            r_hnz  <= 1'b0;
            for (int d = 0; d < NUM_DIG; d++) r_cnt[d] <= '0;
        end else if (i_cmd.step) begin
            r_rem  <= low;
            r_term <= nterm;
            r_hnz  <= r_hnz | (cur != '0);
            for (int d = 1; d < NUM_DIG; d++) begin
                if (cur > DIG_W'(d))
                    r_cnt[d] <= r_cnt[d] + r_term + place;
                else if (cur == DIG_W'(d))
                    r_cnt[d] <= r_cnt[d] + r_term + low1;
                else
                    r_cnt[d] <= r_cnt[d] + r_term;
            end
            if (r_hnz) begin
                if (cur != '0)
                    r_cnt[0] <= r_cnt[0] + r_term;
                else
                    r_cnt[0] <= r_cnt[0] + r_term - place + low1;
            end
        end
    end

    assign o_count = r_cnt[i_cmd.idx];
endmodule
`default_nettype wire

FILE: hdl/decimal_digit_occurrence_counter_core.sv
// Top level of the decimal digit occurrence counter.
// Joins dodc_ctrl and dodc_dpath; depends on dodc_pkg.
// One query passes through an accept in idle, one calculation step per decimal position
// (walked by the controller), then ten output transactions.
// The next query is accepted after the last result.
`default_nettype none
module decimal_digit_occurrence_counter_core
    import dodc_pkg::*;
#(
    parameter int DIGITS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [LIMIT_W-1:0] i_upper_limit,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic      [DIG_W-1:0]   o_digit_value,
    output logic      [CNT_W-1:0]   o_occurrence_count,
    output logic                    o_last_of_run
);
    t_cmd cmd;

    dodc_ctrl #(.DIGITS(DIGITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_last      (o_last_of_run),
        .o_cmd       (cmd)
    );

    dodc_dpath #(.DIGITS(DIGITS)) u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_upper_limit (i_upper_limit),
        .o_count       (o_occurrence_count)
    );

    assign o_digit_value = cmd.idx;
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for decimal_digit_occurrence_counter_core.
// Sends upper limits, predicts the ten per-digit counts of each and checks every result.
// Depends on dodc_pkg and the core RTL.
`default_nettype none
module tb;
    import dodc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS = 10;

    typedef struct {
        logic [DIG_W-1:0] digit;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_digit_count;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [LIMIT_W-1:0] i_upper_limit;
    logic               o_valid;
    logic               i_ready;
    logic [DIG_W-1:0]   o_digit_value;
    logic [CNT_W-1:0]   o_occurrence_count;
    logic               o_last_of_run;

    t_digit_count expected_counts[$];
    int           fail_cnt;
    bit           no_idle;

    decimal_digit_occurrence_counter_core #(.DIGITS(DIGITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_upper_limit(i_upper_limit),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_digit_value(o_digit_value), .o_occurrence_count(o_occurrence_count),
        .o_last_of_run(o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic predict_digit_counts(input logic [LIMIT_W-1:0] limit);
        logic [63:0] counts [0:NUM_DIG-1];
        logic [63:0] n;
        logic [63:0] place;
        logic [63:0] hi;
        logic [63:0] cur;
        logic [63:0] lo;
        logic [63:0] top;
        t_digit_count r;
        n = 64'(limit);
        place = 64'd1;
        top = 64'd1;
        for (int i = 0; i < DIGITS; i++) top = top * 64'd10;
        top = top - 64'd1;
        if (n > top) n = top;
        for (int d = 0; d < NUM_DIG; d++) counts[d] = '0;
        for (int p = 0; p < DIGITS; p++) begin
            hi  = n / (place * 64'd10);
            cur = (n / place) % 64'd10;
            lo  = n % place;
            for (int d = 1; d < NUM_DIG; d++) begin
                counts[d] += hi * place;
                if (cur > 64'(d)) counts[d] += place;
                else if (cur == 64'(d)) counts[d] += lo + 64'd1;
            end
            if (hi > 0) begin
                counts[0] += (hi - 64'd1) * place;
                if (cur > 0) counts[0] += place;
                else counts[0] += lo + 64'd1;
            end
            if (p + 1 < DIGITS) place = place * 64'd10;
        end
        for (int d = 0; d < NUM_DIG; d++) begin
            r.digit = DIG_W'(d);
            r.count = counts[d][CNT_W-1:0];
            r.last  = (d == NUM_DIG - 1);
            expected_counts.push_back(r);
        end
    endtask

    task automatic send_limit(input logic [LIMIT_W-1:0] limit);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_upper_limit <= limit;
        predict_digit_counts(limit);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_digit_count e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_counts.size() == 0) begin
                $error("result with no transaction pending: digit %0d", o_digit_value);
                fail_cnt++;
            end else begin
                e = expected_counts.pop_front();
                if (o_digit_value !== e.digit) begin
                    $error("digit_value exp %0d got %0d", e.digit, o_digit_value);
                    fail_cnt++;
                end
                if (o_occurrence_count !== e.count) begin
                    $error("occurrence_count exp %0d got %0d", e.count, o_occurrence_count);
                    fail_cnt++;
                end
                if (o_last_of_run !== e.last) begin
                    $error("last_of_run exp %0d got %0d", e.last, o_last_of_run);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (no_idle || $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(posedge i_clk);
            end
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        logic [LIMIT_W-1:0] list [$];
        list = '{34'd0, 34'd1, 34'd9, 34'd10, 34'd11, 34'd99, 34'd100, 34'd101,
                 34'd1000, 34'd12345, 34'd100000, 34'd999999999, 34'd1000000000,
                 34'd9999999999, 34'd9999999998, 34'd10000000000,
                 {LIMIT_W{1'b1}}, 34'h2AAAAAAAA, 34'h155555555, 34'd5000000000};
        foreach (list[i]) send_limit(list[i]);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        send_limit(34'd909090909);
        wait_drained();
    endtask

    task automatic test_random(input int cnt);
        logic [LIMIT_W-1:0] v;
        for (int i = 0; i < cnt; i++) begin
            case ($urandom_range(0, 3))
                0: v = LIMIT_W'($urandom_range(0, 1000));
                1: v = LIMIT_W'({$urandom, $urandom} % 64'd10000000000);
                2: v = LIMIT_W'({$urandom, $urandom});
                default: v = LIMIT_W'($urandom_range(0, 9)) * LIMIT_W'(1000000000)
                             + LIMIT_W'($urandom_range(0, 999999999));
            endcase
            send_limit(v);
        end
    endtask

    initial begin
        fail_cnt = 0;
        no_idle = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_upper_limit <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_drain_pause();
        test_random(200);
        no_idle = 1'b1;
        test_random(40);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("decimal_digit_occurrence_counter_core test passed");
        end else begin
            $display("decimal_digit_occurrence_counter_core test failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("decimal_digit_occurrence_counter_core test failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: decimal_digit_occurrence_counter_core.f
hdl/dodc_pkg.sv
hdl/dodc_ctrl.sv
hdl/dodc_dpath.sv
hdl/decimal_digit_occurrence_counter_core.sv
tb/sv/tb.sv
